// ----- hw/rtl/onewire_sensor_frame_checker_top_macros.svh -----
// Assertion macros for the frame checker verification, used by osfc_checker.sv.
`ifndef ONEWIRE_SENSOR_FRAME_CHECKER_TOP_MACROS_SVH
`define ONEWIRE_SENSOR_FRAME_CHECKER_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define OSFC_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define OSFC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/osfc_pkg.sv -----
// Types and constants of the one-wire sensor frame checker.
package osfc_pkg;

    localparam int ROM_DATA_BYTES = 7;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [1:0] CMD_ROM    = 2'd0;
    localparam logic [1:0] CMD_PAD    = 2'd1;
    localparam logic [1:0] CMD_ABSENT = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CRC_FAIL  = 2'd1;
    localparam logic [1:0] STATUS_NO_DEVICE = 2'd2;

    localparam logic KIND_ROM = 1'b0;
    localparam logic KIND_PAD = 1'b1;

    localparam logic [7:0] CFG_9BIT  = 8'h1F;
    localparam logic [7:0] CFG_10BIT = 8'h3F;
    localparam logic [7:0] CFG_11BIT = 8'h5F;
    localparam logic [7:0] CFG_12BIT = 8'h7F;

    localparam logic [2:0] RES_9BIT    = 3'd0;
    localparam logic [2:0] RES_10BIT   = 3'd1;
    localparam logic [2:0] RES_11BIT   = 3'd2;
    localparam logic [2:0] RES_12BIT   = 3'd3;
    localparam logic [2:0] RES_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic       first_byte;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               frame_kind;
        logic signed [15:0] temperature_now;
        logic signed [15:0] temperature_before;
        logic [2:0]         resolution;
        logic [7:0]         fail_total;
        logic [7:0]         family;
        logic [47:0]        serial;
        logic               present;
    } t_out_item;

endpackage

// ----- hw/rtl/onewire_sensor_frame_checker_top.sv -----
// One-wire sensor frame checker: CRC-8 check of ROM and scratchpad frames.
// Each accepted CRC byte or absence event yields a registered result item in the next cycle.
// Throughput: one byte item per cycle; the byte-wide CRC update is combinational.
// The input side stalls only while a result item waits and the output is not ready.
// Reset (synchronous, active low) clears CRC, position, temperatures, counters and IDs.
// The frame byte store has no reset; every entry read was written in the same frame.
module onewire_sensor_frame_checker_top #(
    parameter int PAD_DATA_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  osfc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output osfc_pkg::t_out_item  o_out_item
);

    localparam int STORE_DEPTH = (PAD_DATA_BYTES > osfc_pkg::ROM_DATA_BYTES) ?
                                 PAD_DATA_BYTES : osfc_pkg::ROM_DATA_BYTES;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int POS_W = $clog2(STORE_DEPTH + 1);

    function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ osfc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [2:0] decode_res(input logic [7:0] cfg);
        logic [2:0] r;
        unique case (cfg)
            osfc_pkg::CFG_9BIT:  r = osfc_pkg::RES_9BIT;
            osfc_pkg::CFG_10BIT: r = osfc_pkg::RES_10BIT;
            osfc_pkg::CFG_11BIT: r = osfc_pkg::RES_11BIT;
            osfc_pkg::CFG_12BIT: r = osfc_pkg::RES_12BIT;
            default:             r = osfc_pkg::RES_UNKNOWN;
        endcase
        return r;
    endfunction

    logic [7:0]         r_crc, n_crc;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_store [STORE_DEPTH];
    logic [15:0]        r_temp_cur, n_temp_cur;
    logic [15:0]        r_temp_prev, n_temp_prev;
    logic [7:0]         r_cfg, n_cfg;
    logic [7:0]         r_fails, n_fails;
    logic [7:0]         r_family, n_family;
    logic [47:0]        r_serial, n_serial;
    logic               r_present, n_present;
    logic               r_out_valid;
    osfc_pkg::t_out_item r_out, n_out;

    logic               accept;
    logic               store_we;
    logic               emit;
    logic [1:0]         emit_status;
    logic               emit_kind;
    logic [7:0]         crc_eff;
    logic [POS_W-1:0]   pos_eff;
    logic [POS_W-1:0]   data_len;
    logic               good;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign crc_eff  = i_in_item.first_byte ? 8'd0 : r_crc;
    assign pos_eff  = i_in_item.first_byte ? '0 : r_pos;
    assign data_len = (i_in_item.command == osfc_pkg::CMD_ROM) ?
                      POS_W'(osfc_pkg::ROM_DATA_BYTES) : POS_W'(PAD_DATA_BYTES);
    assign good     = (crc_eff == i_in_item.rx_byte);

    always_comb begin
        n_crc       = r_crc;
        n_pos       = r_pos;
        n_temp_cur  = r_temp_cur;
        n_temp_prev = r_temp_prev;
        n_cfg       = r_cfg;
        n_fails     = r_fails;
        n_family    = r_family;
        n_serial    = r_serial;
        n_present   = r_present;
        store_we    = 1'b0;
        emit        = 1'b0;
        emit_status = osfc_pkg::STATUS_OK;
        emit_kind   = osfc_pkg::KIND_ROM;
        unique case (i_in_item.command)
            osfc_pkg::CMD_ABSENT: begin
                n_present   = 1'b0;
                n_crc       = 8'd0;
                n_pos       = '0;
                emit        = 1'b1;
                emit_status = osfc_pkg::STATUS_NO_DEVICE;
            end
            osfc_pkg::CMD_ROM, osfc_pkg::CMD_PAD: begin
                if (pos_eff < data_len) begin
                    store_we = 1'b1;
                    n_crc    = crc_byte(crc_eff, i_in_item.rx_byte);
                    n_pos    = pos_eff + POS_W'(1);
                end else begin
                    n_crc       = 8'd0;
                    n_pos       = '0;
                    emit        = 1'b1;
                    emit_status = good ? osfc_pkg::STATUS_OK : osfc_pkg::STATUS_CRC_FAIL;
                    if (i_in_item.command == osfc_pkg::CMD_ROM) begin
                        emit_kind = osfc_pkg::KIND_ROM;
                        n_present = 1'b1;
                        if (good) begin
                            n_family = r_store[0];
                            n_serial = {r_store[6], r_store[5], r_store[4],
                                        r_store[3], r_store[2], r_store[1]};
                        end
                    end else begin
                        emit_kind = osfc_pkg::KIND_PAD;
                        if (good) begin
                            n_temp_prev = r_temp_cur;
                            n_temp_cur  = {r_store[1], r_store[0]};
                            n_cfg       = r_store[4];
                        end
                    end
                    if (!good) begin
                        n_fails = r_fails + 8'd1;
                    end
                end
            end
            osfc_pkg::CMD_UNUSED: begin
            end
        endcase
    end

    always_comb begin
        n_out.status             = emit_status;
        n_out.frame_kind         = emit_kind;
        n_out.temperature_now    = n_temp_cur;
        n_out.temperature_before = n_temp_prev;
        n_out.resolution         = decode_res(n_cfg);
        n_out.fail_total         = n_fails;
        n_out.family             = n_family;
        n_out.serial             = n_serial;
        n_out.present            = n_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= 8'd0;
            r_pos       <= '0;
            r_temp_cur  <= 16'd0;
            r_temp_prev <= 16'd0;
            r_cfg       <= 8'd0;
            r_fails     <= 8'd0;
            r_family    <= 8'd0;
            r_serial    <= 48'd0;
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_crc       <= n_crc;
                r_pos       <= n_pos;
                r_temp_cur  <= n_temp_cur;
                r_temp_prev <= n_temp_prev;
                r_cfg       <= n_cfg;
                r_fails     <= n_fails;
                r_family    <= n_family;
                r_serial    <= n_serial;
                r_present   <= n_present;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store_we) begin
            r_store[pos_eff[IDX_W-1:0]] <= i_in_item.rx_byte;
        end
        if (accept && emit) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- hw/rtl/osfc_checker.sv -----
// Port-level assertions for the frame checker, bound to the top level.
`include "onewire_sensor_frame_checker_top_macros.svh"

module osfc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input osfc_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input osfc_pkg::t_out_item o_out_item
);

    `OSFC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "Result item valid after reset")

    `OSFC_ASSERT_RUN(a_out_held, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "Stalled result item dropped or changed")

    `OSFC_ASSERT_RUN(a_absent_result, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_item.command == osfc_pkg::CMD_ABSENT |=> o_out_valid && o_out_item.status == osfc_pkg::STATUS_NO_DEVICE && !o_out_item.present, "Absence event did not report no device")

    `OSFC_ASSERT_RUN(a_rom_sets_present, i_clk, i_rst_n, o_out_valid && o_out_item.frame_kind == osfc_pkg::KIND_ROM && o_out_item.status != osfc_pkg::STATUS_NO_DEVICE |-> o_out_item.present, "Finished ROM frame without presence")

    `OSFC_ASSERT_RUN(a_unused_silent, i_clk, i_rst_n, i_in_valid && o_in_ready && !o_out_valid && i_in_item.command == osfc_pkg::CMD_UNUSED |=> !o_out_valid, "Unused command produced a result item")

endmodule

bind onewire_sensor_frame_checker_top osfc_checker u_osfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ----- sim/tb_onewire_sensor_frame_checker_top.sv -----
// Self-checking testbench of the one-wire sensor frame checker, with random traffic.
module tb_onewire_sensor_frame_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAD_LEN      = 8;
    localparam int ROM_LEN      = osfc_pkg::ROM_DATA_BYTES;
    localparam int RANDOM_ITEMS = 1400;
    localparam int STEADY_ITEMS = 250;

    typedef logic [7:0] t_frame_bytes [8];

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    osfc_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    osfc_pkg::t_out_item out_item;

    bit src_idle    = 1'b1;
    bit sink_idle   = 1'b1;
    int hold_cycles = 0;
    int items_sent  = 0;
    int mismatches  = 0;

    // Predicted state of the sensor frame checker.
    logic [7:0]         crc_run      = '0;
    logic [3:0]         frame_pos    = '0;
    logic [7:0]         frame_bytes [8];
    logic signed [15:0] temp_now     = '0;
    logic signed [15:0] temp_before  = '0;
    logic [7:0]         cfg_seen     = '0;
    logic [7:0]         crc_failures = '0;
    logic [7:0]         family_id    = '0;
    logic [47:0]        serial_id    = '0;
    logic               device_seen  = 1'b0;

    osfc_pkg::t_out_item pending_reports [$];

    onewire_sensor_frame_checker_top #(
        .PAD_DATA_BYTES(PAD_LEN)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always #2 clk = ~clk;

    function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
        logic [7:0] c;
        int         k;
        c = acc ^ b;
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ osfc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [2:0] resolution_of(logic [7:0] cfg);
        case (cfg)
            osfc_pkg::CFG_9BIT:  return osfc_pkg::RES_9BIT;
            osfc_pkg::CFG_10BIT: return osfc_pkg::RES_10BIT;
            osfc_pkg::CFG_11BIT: return osfc_pkg::RES_11BIT;
            osfc_pkg::CFG_12BIT: return osfc_pkg::RES_12BIT;
            default:             return osfc_pkg::RES_UNKNOWN;
        endcase
    endfunction

    function automatic osfc_pkg::t_out_item sensor_report(logic [1:0] st, logic kind);
        osfc_pkg::t_out_item r;
        r.status             = st;
        r.frame_kind         = kind;
        r.temperature_now    = temp_now;
        r.temperature_before = temp_before;
        r.resolution         = resolution_of(cfg_seen);
        r.fail_total         = crc_failures;
        r.family             = family_id;
        r.serial             = serial_id;
        r.present            = device_seen;
        return r;
    endfunction

    function automatic string fmt_report(osfc_pkg::t_out_item r);
        return {$sformatf("st=%0d kind=%0d now=%0d before=%0d res=%0d ",
                          r.status, r.frame_kind, r.temperature_now,
                          r.temperature_before, r.resolution),
                $sformatf("fails=%0d fam=%h ser=%h pres=%0d",
                          r.fail_total, r.family, r.serial, r.present)};
    endfunction

    task automatic track_frame_byte(osfc_pkg::t_in_item it);
        int   len;
        logic good;
        if (it.command == osfc_pkg::CMD_ABSENT) begin
            device_seen = 1'b0;
            crc_run     = '0;
            frame_pos   = '0;
            pending_reports.push_back(sensor_report(osfc_pkg::STATUS_NO_DEVICE,
                                                    osfc_pkg::KIND_ROM));
        end else if (it.command != osfc_pkg::CMD_UNUSED) begin
            if (it.first_byte) begin
                crc_run   = '0;
                frame_pos = '0;
            end
            len = (it.command == osfc_pkg::CMD_ROM) ? ROM_LEN : PAD_LEN;
            if (int'(frame_pos) < len) begin
                frame_bytes[frame_pos[2:0]] = it.rx_byte;
                crc_run   = crc8_next(crc_run, it.rx_byte);
                frame_pos = frame_pos + 4'd1;
            end else begin
                good = (crc_run == it.rx_byte);
                if (it.command == osfc_pkg::CMD_ROM) begin
                    device_seen = 1'b1;
                    if (good) begin
                        family_id = frame_bytes[0];
                        serial_id = {frame_bytes[6], frame_bytes[5], frame_bytes[4],
                                     frame_bytes[3], frame_bytes[2], frame_bytes[1]};
                    end
                end else if (good) begin
                    temp_before = temp_now;
                    temp_now    = {frame_bytes[1], frame_bytes[0]};
                    cfg_seen    = frame_bytes[4];
                end
                if (!good) begin
                    crc_failures = crc_failures + 8'd1;
                end
                crc_run   = '0;
                frame_pos = '0;
                pending_reports.push_back(sensor_report(
                    good ? osfc_pkg::STATUS_OK : osfc_pkg::STATUS_CRC_FAIL,
                    (it.command == osfc_pkg::CMD_PAD) ? osfc_pkg::KIND_PAD
                                                      : osfc_pkg::KIND_ROM));
            end
        end
    endtask

    task automatic offer_byte(logic [1:0] cmd, logic first, logic [7:0] b);
        osfc_pkg::t_in_item it;
        it.command    = cmd;
        it.first_byte = first;
        it.rx_byte    = b;
        if (src_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        track_frame_byte(it);
        if (cmd != osfc_pkg::CMD_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic send_frame(logic [1:0] cmd, t_frame_bytes data, logic corrupt, logic mark);
        logic [7:0] crc;
        int         len;
        int         i;
        len = (cmd == osfc_pkg::CMD_ROM) ? ROM_LEN : PAD_LEN;
        crc = '0;
        for (i = 0; i < len; i++) begin
            crc = crc8_next(crc, data[i]);
            offer_byte(cmd, (i == 0) ? (mark || frame_pos != 0) : 1'b0, data[i]);
        end
        if (corrupt) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        offer_byte(cmd, 1'b0, crc);
    endtask

    function automatic t_frame_bytes random_frame_bytes(logic [1:0] cmd);
        t_frame_bytes d;
        int           i;
        for (i = 0; i < 8; i++) begin
            d[i] = 8'($urandom);
        end
        if (cmd == osfc_pkg::CMD_PAD && $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
                0:       d[4] = osfc_pkg::CFG_9BIT;
                1:       d[4] = osfc_pkg::CFG_10BIT;
                2:       d[4] = osfc_pkg::CFG_11BIT;
                default: d[4] = osfc_pkg::CFG_12BIT;
            endcase
        end
        return d;
    endfunction

    task automatic test_after_reset();
        offer_byte(osfc_pkg::CMD_ABSENT, 1'b1, 8'h00);
        offer_byte(osfc_pkg::CMD_UNUSED, 1'b1, 8'hFF);
    endtask

    task automatic test_rom_frame();
        t_frame_bytes d;
        d = '{default: 8'hFF};
        send_frame(osfc_pkg::CMD_ROM, d, 1'b0, 1'b0);
    endtask

    task automatic test_pad_frame();
        t_frame_bytes d;
        d = '{8'h00, 8'h80, 8'h4B, 8'h46, osfc_pkg::CFG_12BIT, 8'hFF, 8'h0C, 8'h10};
        send_frame(osfc_pkg::CMD_PAD, d, 1'b0, 1'b1);
    endtask

    task automatic test_bad_crc();
        t_frame_bytes d;
        d = '{default: 8'h00};
        send_frame(osfc_pkg::CMD_ROM, d, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(int n);
        int         target;
        int         pick;
        logic [1:0] cmd;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            cmd  = 2'($urandom_range(0, 1));
            if (pick < 70) begin
                send_frame(cmd, random_frame_bytes(cmd), $urandom_range(0, 3) == 0,
                           1'($urandom_range(0, 1)));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 8)) begin
                    offer_byte(2'($urandom_range(0, 1)), 1'b0, 8'($urandom));
                end
            end else if (pick < 90) begin
                offer_byte(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
            end else if (pick < 95) begin
                offer_byte(osfc_pkg::CMD_ABSENT, 1'($urandom), 8'($urandom));
            end else begin
                offer_byte(osfc_pkg::CMD_UNUSED, 1'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic test_output_hold();
        src_idle    = 1'b0;
        sink_idle   = 1'b0;
        hold_cycles = 60;
        repeat (3) begin
            send_frame(osfc_pkg::CMD_ROM, random_frame_bytes(osfc_pkg::CMD_ROM), 1'b0, 1'b0);
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_frame(osfc_pkg::CMD_PAD, random_frame_bytes(osfc_pkg::CMD_PAD), 1'b0, 1'b0);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        send_frame(osfc_pkg::CMD_PAD, random_frame_bytes(osfc_pkg::CMD_PAD), 1'b0, 1'b1);
    endtask

    task automatic test_steady_stream();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        test_random_traffic(STEADY_ITEMS);
    endtask

    task automatic note_mismatch(string what, osfc_pkg::t_out_item want,
                                 osfc_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t:%s", $realtime, what);
            $display("  expected %s", fmt_report(want));
            $display("  actual   %s", fmt_report(got));
        end
    endtask

    always @(posedge clk) begin : report_check
        osfc_pkg::t_out_item want;
        string               bad;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                note_mismatch(" unexpected item", '0, out_item);
            end else begin
                want = pending_reports.pop_front();
                bad  = "";
                if (out_item.status !== want.status) bad = {bad, " status"};
                if (out_item.frame_kind !== want.frame_kind) bad = {bad, " frame_kind"};
                if (out_item.temperature_now !== want.temperature_now) bad = {bad, " now"};
                if (out_item.temperature_before !== want.temperature_before) begin
                    bad = {bad, " before"};
                end
                if (out_item.resolution !== want.resolution) bad = {bad, " resolution"};
                if (out_item.fail_total !== want.fail_total) bad = {bad, " fail_total"};
                if (out_item.family !== want.family) bad = {bad, " family"};
                if (out_item.serial !== want.serial) bad = {bad, " serial"};
                if (out_item.present !== want.present) bad = {bad, " present"};
                if (bad != "") begin
                    note_mismatch(bad, want, out_item);
                end
            end
        end
    end

    initial begin : sink_pacing
        int n;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : run_tests
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_rom_frame();
        test_pad_frame();
        test_bad_crc();
        test_output_hold();
        test_drain_pause();
        test_random_traffic(RANDOM_ITEMS);
        test_steady_stream();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule
